@@ hw/rtl/lfu_pkg.sv @@
// lfu_pkg: shared types and constants for the lfu cache core
// used by lfu_cell and lfu_cache_core; depends on nothing else
`timescale 1ns / 1ps

package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int CAP_W   = 5;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic [VALUE_W-1:0] READ_MISS = '1;
	localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);

	typedef struct packed {
		logic                      command;
		logic signed [KEY_W-1:0]   key;
		logic signed [VALUE_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic                      hit;
		logic signed [VALUE_W-1:0] read_value;
		logic                      evicted;
	} rsp_word_t;

	// update broadcast from the sequencer to every cell
	typedef struct packed {
		logic               en;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} cell_cmd_t;

endpackage

@@ hw/rtl/lfu_cell.sv @@
// lfu_cell: one slot of the sorted entry row (key, value, use count)
// takes its left neighbor's entry on an insertion shift; depends on lfu_pkg
`timescale 1ns / 1ps

module lfu_cell #(
	parameter int POS        = 0,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5,
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  lfu_pkg::cell_cmd_t             cmd,
	input  logic [COUNT_BITS-1:0]          new_count,
	input  logic [IDX_W-1:0]               remove_idx,
	input  logic [CNT_W-1:0]               fill,
	input  logic [lfu_pkg::KEY_W-1:0]      probe_key,
	input  logic [lfu_pkg::KEY_W-1:0]      prev_key,
	input  logic [lfu_pkg::VALUE_W-1:0]    prev_value,
	input  logic [COUNT_BITS-1:0]          prev_count,
	input  logic                           prev_gt,
	output logic [lfu_pkg::KEY_W-1:0]      key,
	output logic [lfu_pkg::VALUE_W-1:0]    value,
	output logic [COUNT_BITS-1:0]          count,
	output logic                           gt,
	output logic                           match
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(POS);
	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(POS);

	logic [lfu_pkg::KEY_W-1:0]   key_q;
	logic [lfu_pkg::VALUE_W-1:0] value_q;
	logic [COUNT_BITS-1:0]       count_q;
	logic                        live;
	logic                        in_span;
	logic                        load_new;
	logic                        shift;

	assign live  = MY_POS < fill;
	assign match = live && (key_q == probe_key);

	// entries ahead of the insertion point stay put
	assign gt      = (MY_IDX < remove_idx) && (count_q > new_count);
	assign in_span = MY_IDX <= remove_idx;

	assign load_new = cmd.en && in_span && !gt && prev_gt;
	assign shift    = cmd.en && in_span && !gt && !prev_gt;

	always_ff @(posedge clk) begin
		priority if (load_new) begin
			key_q   <= cmd.key;
			value_q <= cmd.value;
			count_q <= new_count;
		end else if (shift) begin
			key_q   <= prev_key;
			value_q <= prev_value;
			count_q <= prev_count;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign count = count_q;

endmodule

@@ hw/rtl/lfu_cache_core.sv @@
// lfu_cache_core: fully associative lfu cache with lru tiebreak, top level
// sequencer plus a row of lfu_cell slots; depends on lfu_pkg and lfu_cell
//
// usage:
//   req channel (req_valid / req_stall / req) carries one word per get or put.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one word per request:
//   hit flag, read value (-1 on get miss, 0 on put) and evicted flag.
//   cfg_wr_en / cfg_wr_data write the capacity; only while the core is idle.
// timing:
//   a request is a match against every slot at acceptance, a gather
//   of the matching slot, then one shift step along the cell row. the
//   response is registered and valid after the update step; req_stall is
//   high from acceptance until the update step ends; no word is taken
//   meanwhile. a new request is accepted while a response still waits on
//   rsp_stall; its update step holds until that response has been taken.
// ordering:
//   slots are kept sorted by use count, most recent first within a count;
//   the eviction candidate is always the last occupied slot.
// reset:
//   all slots empty (fill count zero), capacity 16, no response pending.
`timescale 1ns / 1ps

module lfu_cache_core #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  lfu_pkg::req_word_t            req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output lfu_pkg::rsp_word_t            rsp,
	input  logic                          cfg_wr_en,
	input  logic [lfu_pkg::CAP_W-1:0]     cfg_wr_data
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GATH = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]                   state_q;
	logic [lfu_pkg::CAP_W-1:0]    capacity_q;
	logic [CNT_W-1:0]             fill_q;
	logic [CNT_W-1:0]             fill_dec;

	logic                         cmd_q;
	logic [lfu_pkg::KEY_W-1:0]    item_key_q;
	logic [lfu_pkg::VALUE_W-1:0]  item_value_q;
	logic [ENTRIES-1:0]           match_q;

	logic                         hit_c;
	logic [IDX_W-1:0]             ridx_c;
	logic [lfu_pkg::VALUE_W-1:0]  rval_c;
	logic [COUNT_BITS-1:0]        rcnt_c;
	logic                         hit_q;
	logic [IDX_W-1:0]             ridx_q;
	logic [lfu_pkg::VALUE_W-1:0]  rval_q;
	logic [COUNT_BITS-1:0]        rcnt_q;

	logic                         rsp_valid_q;
	lfu_pkg::rsp_word_t           rsp_q;

	logic [lfu_pkg::KEY_W-1:0]    key_w   [ENTRIES];
	logic [lfu_pkg::VALUE_W-1:0]  value_w [ENTRIES];
	logic [COUNT_BITS-1:0]        count_w [ENTRIES];
	logic [ENTRIES-1:0]           gt_w;
	logic [ENTRIES-1:0]           match_w;

	lfu_pkg::cell_cmd_t           cell_cmd;
	logic [COUNT_BITS-1:0]        new_count;
	logic [IDX_W-1:0]             remove_idx;
	logic                         adv;
	logic                         grow;
	logic                         do_upd;
	logic [lfu_pkg::VALUE_W-1:0]  rd_c;
	logic                         ev_c;
	logic [31:0]                  cap_ext;
	logic [31:0]                  cap_eff;
	logic [31:0]                  fill_ext;
	logic [COUNT_BITS-1:0]        bump_cnt;

	// ---------------- cell row ----------------
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lfu_cell #(
			.POS        (i),
			.IDX_W      (IDX_W),
			.CNT_W      (CNT_W),
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.new_count  (new_count),
			.remove_idx (remove_idx),
			.fill       (fill_q),
			.probe_key  (req.key),
			.prev_key   ((i == 0) ? '0 : key_w[(i == 0) ? 0 : i - 1]),
			.prev_value ((i == 0) ? '0 : value_w[(i == 0) ? 0 : i - 1]),
			.prev_count ((i == 0) ? '0 : count_w[(i == 0) ? 0 : i - 1]),
			.prev_gt    ((i == 0) ? 1'b1 : gt_w[(i == 0) ? 0 : i - 1]),
			.key        (key_w[i]),
			.value      (value_w[i]),
			.count      (count_w[i]),
			.gt         (gt_w[i]),
			.match      (match_w[i])
		);
	end

	// ---------------- gather of the matching slot ----------------
	always_comb begin
		hit_c  = |match_q;
		ridx_c = '0;
		rval_c = '0;
		rcnt_c = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_q[i]) begin
				ridx_c = ridx_c | IDX_W'(i);
				rval_c = rval_c | value_w[i];
				rcnt_c = rcnt_c | count_w[i];
			end
		end
	end

	// ---------------- update decision ----------------
	assign cap_ext  = 32'(capacity_q);
	assign cap_eff  = (cap_ext > 32'(ENTRIES)) ? 32'(ENTRIES) : cap_ext;
	assign fill_ext = 32'(fill_q);
	assign fill_dec = fill_q - CNT_W'(1);
	assign bump_cnt = (rcnt_q == '1) ? rcnt_q : rcnt_q + COUNT_BITS'(1);

	assign adv = (state_q == ST_UPD) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		do_upd     = 1'b0;
		grow       = 1'b0;
		ev_c       = 1'b0;
		rd_c       = '0;
		remove_idx = ridx_q;
		new_count  = bump_cnt;
		cell_cmd.key   = item_key_q;
		cell_cmd.value = rval_q;
		unique case (cmd_q)
			lfu_pkg::CMD_GET: begin
				if (hit_q) begin
					do_upd = 1'b1;
					rd_c   = rval_q;
				end else begin
					rd_c = lfu_pkg::READ_MISS;
				end
			end
			lfu_pkg::CMD_PUT: begin
				if (cap_eff != 32'd0) begin
					do_upd         = 1'b1;
					cell_cmd.value = item_value_q;
					if (!hit_q) begin
						new_count = '0;
						if (fill_ext < cap_eff) begin
							// free slot at the tail
							remove_idx = fill_q[IDX_W-1:0];
							grow       = 1'b1;
						end else begin
							// drop the last occupied slot
							remove_idx = fill_dec[IDX_W-1:0];
							ev_c       = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		cell_cmd.en = adv && do_upd;
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			capacity_q  <= lfu_pkg::CAP_RESET;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_GATH;
					end
				end
				ST_GATH: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (adv && grow) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req_valid) begin
			cmd_q        <= req.command;
			item_key_q   <= req.key;
			item_value_q <= req.value;
			match_q      <= match_w;
		end
		if (state_q == ST_GATH) begin
			hit_q  <= hit_c;
			ridx_q <= ridx_c;
			rval_q <= rval_c;
			rcnt_q <= rcnt_c;
		end
		if (adv) begin
			rsp_q.hit        <= hit_q;
			rsp_q.read_value <= rd_c;
			rsp_q.evicted    <= ev_c;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------- assertions ----------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(ENTRIES))
		else $error("fill count beyond slot count");

	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GATH) |-> $onehot0(match_q))
		else $error("key present in more than one slot");

	a_rsp_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_UPD))
		else $error("response raised outside the update step");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("fill count moved by other than one");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.hit && rsp_q.evicted))
		else $error("eviction reported on a hit");

endmodule

@@ sim/lfu_cache_core_test.sv @@
// lfu_cache_core_test: self-checking bench for the lfu cache core, with its own cache predictor
// depends on lfu_pkg and lfu_cache_core; directed cases first, then randomized capacity phases
`timescale 1ns / 1ps

module lfu_cache_core_test;

	localparam int ENTRIES       = 16;
	localparam int COUNT_BITS    = 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int HOT_GETS      = 12;
	localparam logic [lfu_pkg::KEY_W-1:0] KEY_HOT  = 32'h0000_0A11;
	localparam logic [lfu_pkg::KEY_W-1:0] KEY_WARM = 32'h0000_0B22;
	localparam logic [lfu_pkg::KEY_W-1:0] KEY_NEW  = 32'h0000_0C33;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_stall;
	lfu_pkg::req_word_t        req = '0;
	logic                      rsp_valid;
	logic                      rsp_stall = 1'b0;
	lfu_pkg::rsp_word_t        rsp;
	logic                      cfg_wr_en = 1'b0;
	logic [lfu_pkg::CAP_W-1:0] cfg_wr_data = '0;

	// predictor state: slot contents, use counts and recency age (0 = most recent)
	logic                           slot_used  [ENTRIES];
	logic [lfu_pkg::KEY_W-1:0]      slot_key   [ENTRIES];
	logic [lfu_pkg::VALUE_W-1:0]    slot_value [ENTRIES];
	logic [COUNT_BITS-1:0]          slot_uses  [ENTRIES];
	int                             slot_age   [ENTRIES];
	logic [lfu_pkg::CAP_W-1:0]      cap_reg;

	lfu_pkg::rsp_word_t lookup_results[$];
	lfu_pkg::rsp_word_t want_rsp;
	int        bad_words = 0;
	int        cycles = 0;
	int        stall_hold = 0;
	logic      idling = 1'b1;

	lfu_cache_core #(
		.ENTRIES   (ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("lfu_cache_core_test NOT OK");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idling || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			rsp_stall <= 1'b1;
			stall_hold <= stall_hold - 1;
		end else begin
			rsp_stall <= 1'b0;
			if ($urandom_range(0, 2) == 0)
				stall_hold <= pick_gap();
		end
	end

	task automatic flag_bad(input string what, input logic [lfu_pkg::VALUE_W-1:0] want,
			input logic [lfu_pkg::VALUE_W-1:0] got);
		bad_words++;
		if (bad_words <= 10)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (lookup_results.size() == 0) begin
				flag_bad("word with nothing pending", '0, rsp.read_value);
			end else begin
				want_rsp = lookup_results[0];
				lookup_results.delete(0);
				if (rsp.hit !== want_rsp.hit)
					flag_bad("hit", lfu_pkg::VALUE_W'(want_rsp.hit),
						lfu_pkg::VALUE_W'(rsp.hit));
				if (rsp.read_value !== want_rsp.read_value)
					flag_bad("read_value", want_rsp.read_value, rsp.read_value);
				if (rsp.evicted !== want_rsp.evicted)
					flag_bad("evicted", lfu_pkg::VALUE_W'(want_rsp.evicted),
						lfu_pkg::VALUE_W'(rsp.evicted));
			end
		end
	end

	// make idx the most recent; entries newer than its old age get one step older
	task automatic make_recent(input int idx, input logic was_used);
		int old;
		old = was_used ? slot_age[idx] : ENTRIES;
		for (int i = 0; i < ENTRIES; i++) begin
			if (i != idx && slot_used[i] && slot_age[i] < old)
				slot_age[i]++;
		end
		slot_age[idx] = 0;
	endtask

	task automatic count_use(input int idx);
		if (slot_uses[idx] < COUNT_MAX)
			slot_uses[idx]++;
		make_recent(idx, 1'b1);
	endtask

	task automatic lfu_apply(input lfu_pkg::req_word_t w, output lfu_pkg::rsp_word_t r);
		int found, free_slot, victim, slot, nused, cap, gone;
		found = -1;
		free_slot = -1;
		victim = -1;
		nused = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_used[i]) begin
				nused++;
				if (found < 0 && slot_key[i] == w.key)
					found = i;
				if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
						(slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim]))
					victim = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		r.hit = (found >= 0);
		r.read_value = '0;
		r.evicted = 1'b0;
		cap = (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
		if (w.command == lfu_pkg::CMD_GET) begin
			if (found >= 0) begin
				r.read_value = slot_value[found];
				count_use(found);
			end else begin
				r.read_value = lfu_pkg::READ_MISS;
			end
		end else if (cap != 0) begin
			if (found >= 0) begin
				slot_value[found] = w.value;
				count_use(found);
			end else begin
				if (nused < cap && free_slot >= 0) begin
					slot = free_slot;
				end else begin
					slot = victim;
					r.evicted = (victim >= 0);
				end
				if (slot >= 0) begin
					// take the victim out of the recency order before reuse
					if (r.evicted) begin
						gone = slot_age[slot];
						for (int i = 0; i < ENTRIES; i++) begin
							if (i != slot && slot_used[i] && slot_age[i] > gone)
								slot_age[i]--;
						end
					end
					slot_used[slot] = 1'b0;
					make_recent(slot, 1'b0);
					slot_used[slot] = 1'b1;
					slot_key[slot] = w.key;
					slot_value[slot] = w.value;
					slot_uses[slot] = '0;
				end
			end
		end
	endtask

	task automatic issue(input logic cmd, input logic [lfu_pkg::KEY_W-1:0] k,
			input logic [lfu_pkg::VALUE_W-1:0] v);
		lfu_pkg::req_word_t w;
		lfu_pkg::rsp_word_t r;
		int gap;
		w.command = cmd;
		w.key = k;
		w.value = v;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		lfu_apply(w, r);
		lookup_results = {lookup_results, r};
	endtask

	task automatic settle();
		@(negedge clk) req_valid <= 1'b0;
		while (lookup_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [lfu_pkg::CAP_W-1:0] c);
		settle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(negedge clk) cfg_wr_en <= 1'b0;
		cap_reg = c;
	endtask

	// a much used key outlasts a less used one when the cache is full
	task automatic test_frequency();
		idling = 1'b0;
		set_capacity(2);
		issue(lfu_pkg::CMD_GET, KEY_HOT, '0);
		issue(lfu_pkg::CMD_PUT, KEY_HOT, 32'h1111_2222);
		for (int i = 0; i < HOT_GETS; i++)
			issue(lfu_pkg::CMD_GET, KEY_HOT, '0);
		issue(lfu_pkg::CMD_PUT, KEY_WARM, 32'h3333_4444);
		for (int i = 0; i < 10; i++)
			issue(lfu_pkg::CMD_GET, KEY_WARM, '0);
		issue(lfu_pkg::CMD_PUT, KEY_NEW, 32'h5555_6666);
		issue(lfu_pkg::CMD_GET, KEY_HOT, '0);
		issue(lfu_pkg::CMD_GET, KEY_WARM, '0);
		idling = 1'b1;
	endtask

	task automatic test_key_extremes();
		set_capacity(16);
		issue(lfu_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		issue(lfu_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		issue(lfu_pkg::CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue(lfu_pkg::CMD_GET, 32'h8000_0000, '0);
		issue(lfu_pkg::CMD_PUT, '0, '0);
		issue(lfu_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(lfu_pkg::CMD_GET, 32'hFFFF_FFFF, '0);
		issue(lfu_pkg::CMD_GET, '0, '0);
		issue(lfu_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
		issue(lfu_pkg::CMD_GET, 32'h7FFF_FFFF, '0);
		issue(lfu_pkg::CMD_GET, 32'h0000_0001, '0);
	endtask

	// more live entries than the new capacity: each new key replaces a victim
	task automatic test_lowered_capacity();
		set_capacity(1);
		issue(lfu_pkg::CMD_PUT, 32'h0000_0055, 32'hA5A5_A5A5);
		issue(lfu_pkg::CMD_PUT, 32'h0000_00AA, 32'h5A5A_5A5A);
		issue(lfu_pkg::CMD_GET, 32'h0000_0055, '0);
		issue(lfu_pkg::CMD_GET, 32'h0000_00AA, '0);
	endtask

	task automatic test_zero_capacity();
		set_capacity(0);
		issue(lfu_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0005);
		issue(lfu_pkg::CMD_PUT, 32'h0000_1234, 32'h0000_0006);
		issue(lfu_pkg::CMD_GET, 32'h0000_1234, '0);
		issue(lfu_pkg::CMD_GET, 32'hFFFF_FFFF, '0);
	endtask

	task automatic test_random();
		logic [lfu_pkg::CAP_W-1:0] caps [10];
		logic [lfu_pkg::KEY_W-1:0] pool [20];
		logic [lfu_pkg::KEY_W-1:0] k;
		int n, eff, live;
		caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd5, 5'd16, 5'd0, 5'd12, 5'd31};
		caps[7] = lfu_pkg::CAP_W'($urandom_range(0, 31));
		for (int p = 0; p < 10; p++) begin
			set_capacity(caps[p]);
			eff = (caps[p] > ENTRIES) ? ENTRIES : int'(caps[p]);
			n = eff + 3;
			// up to half the key pool comes from what the cache holds now
			live = 0;
			for (int j = 0; j < ENTRIES; j++) begin
				if (slot_used[j] && live < n / 2) begin
					pool[live] = slot_key[j];
					live++;
				end
			end
			for (int j = live; j < n; j++)
				pool[j] = $urandom;
			for (int j = 0; j < 160; j++) begin
				if (j % 40 == 0)
					idling = ($urandom_range(0, 3) != 0);
				k = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, n - 1)];
				issue(($urandom_range(0, 1) == 0) ? lfu_pkg::CMD_GET : lfu_pkg::CMD_PUT,
					k, $urandom);
			end
		end
		idling = 1'b1;
	endtask

	initial begin
		cap_reg = lfu_pkg::CAP_RESET;
		for (int i = 0; i < ENTRIES; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i] = '0;
			slot_value[i] = '0;
			slot_uses[i] = '0;
			slot_age[i] = 0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_frequency();
		test_key_extremes();
		test_lowered_capacity();
		test_zero_capacity();
		test_random();

		settle();
		if (bad_words == 0 && lookup_results.size() == 0)
			$display("lfu_cache_core_test OK");
		else
			$display("lfu_cache_core_test NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_cell.sv
hw/rtl/lfu_cache_core.sv
sim/lfu_cache_core_test.sv
